// ===== hdl/oas_pkg.sv =====
// ----------------------------------------------------------------------------
// oas_pkg: shared types and constants for the orbit anomaly solver
// CORDIC arctangent table, fixed-point constants and sequencer state codes.
// ----------------------------------------------------------------------------
package oas_pkg;

    localparam int MaxIterations = 65;
    localparam int AngleBits     = 32;
    localparam int CordicSteps   = 30;
    localparam int PeriodW       = 40;
    localparam int EccW          = 16;
    localparam int InW           = 48;

    localparam logic signed [33:0] CordicGain = 34'sd652032874;
    localparam logic signed [31:0] InvTwoPi   = 32'sd683565276;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_MOD   = 9'b000000010,
        ST_FRAC  = 9'b000000100,
        ST_CHECK = 9'b000001000,
        ST_CORD  = 9'b000010000,
        ST_MUL1  = 9'b000100000,
        ST_MUL2  = 9'b001000000,
        ST_UPD   = 9'b010000000,
        ST_DONE  = 9'b100000000
    } state_t;

    function automatic logic [31:0] atan_turns(input logic [4:0] i);
        logic [31:0] r;
        case (i)
            5'd0:  r = 32'h20000000;
            5'd1:  r = 32'h12E4051E;
            5'd2:  r = 32'h09FB385B;
            5'd3:  r = 32'h051111D4;
            5'd4:  r = 32'h028B0D43;
            5'd5:  r = 32'h0145D7E1;
            5'd6:  r = 32'h00A2F61E;
            5'd7:  r = 32'h00517C55;
            5'd8:  r = 32'h0028BE53;
            5'd9:  r = 32'h00145F2F;
            5'd10: r = 32'h000A2F98;
            5'd11: r = 32'h000517CC;
            5'd12: r = 32'h00028BE6;
            5'd13: r = 32'h000145F3;
            5'd14: r = 32'h0000A2FA;
            5'd15: r = 32'h0000517D;
            5'd16: r = 32'h000028BE;
            5'd17: r = 32'h0000145F;
            5'd18: r = 32'h00000A30;
            5'd19: r = 32'h00000518;
            5'd20: r = 32'h0000028C;
            5'd21: r = 32'h00000146;
            5'd22: r = 32'h000000A3;
            5'd23: r = 32'h00000051;
            5'd24: r = 32'h00000029;
            5'd25: r = 32'h00000014;
            5'd26: r = 32'h0000000A;
            5'd27: r = 32'h00000005;
            5'd28: r = 32'h00000003;
            5'd29: r = 32'h00000001;
            default: r = 32'h0;
        endcase
        return r;
    endfunction

endpackage

// ===== hdl/orbit_anomaly_solver_core.sv =====
// ----------------------------------------------------------------------------
// orbit_anomaly_solver_core: Kepler equation solver
// Mean angle by serial division, then damped fixed-point iteration with a
// shared CORDIC sine unit.
// ----------------------------------------------------------------------------
// Raise start for one cycle while busy is low to transfer a time since
// periapsis. busy stays high until the result appears: done pulses for one
// cycle with anomaly_turns and limit_reached valid in that cycle only; the
// receiver cannot stall, so capture it then. One item runs a restoring
// modulo over the 48 magnitude bits, a 32-bit fraction division (preceded
// by a fold step for a negative time), then per update a check step, 30
// CORDIC rotations and their done step, two multiply steps and the update,
// up to 66 updates, and a final step that presents the result; the CORDIC
// loop sets the worst case.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once and
// must only be made while busy is low.
module orbit_anomaly_solver_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [47:0] days_since_periapsis,
    output logic        done,
    output logic [31:0] anomaly_turns,
    output logic        limit_reached,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [39:0] cfg_data
);

    oas_pkg::state_t state_reg;
    logic [39:0] period_reg;
    logic [15:0] ecc_reg;
    logic [47:0] mag_reg;
    logic [40:0] rem_reg;
    logic        neg_reg;
    logic [5:0]  cnt_reg;
    logic [6:0]  iter_reg;
    logic signed [35:0] mean_reg, ans_reg, prev_reg;
    logic signed [31:0] p_reg;
    logic signed [63:0] t_reg;
    logic        cgo;
    logic        cdone;
    logic signed [33:0] csin;
    logic [40:0] rem_sh, rem_sub;
    logic signed [35:0] t36, ans_new;

    // the rotation starts on the angle that becomes prev in the check step
    oas_cordic u_cordic
    (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (cgo),
        .turn  (ans_reg[31:0]),
        .done  (cdone),
        .sine  (csin)
    );

    always_comb
    begin
        if (state_reg == oas_pkg::ST_MOD)
            rem_sh = {rem_reg[39:0], mag_reg[47]};
        else
            rem_sh = {rem_reg[39:0], 1'b0};
        rem_sub = rem_sh - {1'b0, period_reg};
        // round half up from Q62 to 32 fractional bits
        t36 = 36'((t_reg + 64'sd536870912) >>> 30);
        ans_new = (mean_reg - t36 + prev_reg) >>> 1;
        cgo = (state_reg == oas_pkg::ST_CHECK) && (ans_reg != prev_reg)
              && (iter_reg <= 7'(oas_pkg::MaxIterations));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= oas_pkg::ST_IDLE;
            period_reg    <= 40'd23937441;
            ecc_reg       <= 16'd1095;
            done          <= 1'b0;
            anomaly_turns <= '0;
            limit_reached <= 1'b0;
            cnt_reg       <= '0;
            iter_reg      <= '0;
        end
        else
        begin
            done <= 1'b0;
            if (cfg_we)
            begin
                if (cfg_index)
                    ecc_reg <= cfg_data[15:0];
                else
                    period_reg <= cfg_data;
            end
            case (state_reg)
                oas_pkg::ST_IDLE:
                begin
                    if (start)
                    begin
                        neg_reg  <= days_since_periapsis[47];
                        mag_reg  <= days_since_periapsis[47] ?
                                    (48'd0 - days_since_periapsis) : days_since_periapsis;
                        rem_reg  <= '0;
                        cnt_reg  <= '0;
                        mean_reg <= '0;
                        iter_reg <= '0;
                        state_reg <= oas_pkg::ST_MOD;
                    end
                end
                oas_pkg::ST_MOD:
                begin
                    // restoring modulo, one bit of the magnitude per cycle
                    rem_reg <= rem_sub[40] ? rem_sh : rem_sub;
                    mag_reg <= {mag_reg[46:0], 1'b0};
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd47)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= oas_pkg::ST_FRAC;
                    end
                end
                oas_pkg::ST_FRAC:
                begin
                    if (cnt_reg == 6'd0 && neg_reg && rem_reg != '0)
                    begin
                        rem_reg <= {1'b0, period_reg} - rem_reg;
                        neg_reg <= 1'b0;
                    end
                    else
                    begin
                        rem_reg  <= rem_sub[40] ? rem_sh : rem_sub;
                        mean_reg <= {mean_reg[34:0], ~rem_sub[40]};
                        cnt_reg  <= cnt_reg + 6'd1;
                        if (cnt_reg == 6'd31)
                        begin
                            prev_reg  <= '0;
                            ans_reg   <= {mean_reg[34:0], ~rem_sub[40]};
                            state_reg <= oas_pkg::ST_CHECK;
                        end
                    end
                    if (period_reg == '0)
                    begin
                        ans_reg   <= '0;
                        prev_reg  <= '0;
                        mean_reg  <= '0;
                        state_reg <= oas_pkg::ST_CHECK;
                    end
                end
                oas_pkg::ST_CHECK:
                begin
                    if (ans_reg == prev_reg)
                    begin
                        limit_reached <= 1'b0;
                        state_reg     <= oas_pkg::ST_DONE;
                    end
                    else if (iter_reg > 7'(oas_pkg::MaxIterations))
                    begin
                        limit_reached <= 1'b1;
                        state_reg     <= oas_pkg::ST_DONE;
                    end
                    else
                    begin
                        prev_reg  <= ans_reg;
                        iter_reg  <= iter_reg + 7'd1;
                        state_reg <= oas_pkg::ST_CORD;
                    end
                end
                oas_pkg::ST_CORD:
                begin
                    if (cdone)
                    begin
                        p_reg     <= 32'(50'($signed({1'b0, ecc_reg}) * csin) >>> 16);
                        state_reg <= oas_pkg::ST_MUL1;
                    end
                end
                oas_pkg::ST_MUL1:
                begin
                    t_reg     <= 64'(p_reg) * 64'(oas_pkg::InvTwoPi);
                    state_reg <= oas_pkg::ST_MUL2;
                end
                oas_pkg::ST_MUL2:
                begin
                    ans_reg   <= ans_new;
                    state_reg <= oas_pkg::ST_UPD;
                end
                oas_pkg::ST_UPD:
                begin
                    // limit taken after the update count exceeds the maximum
                    if (iter_reg > 7'(oas_pkg::MaxIterations))
                    begin
                        limit_reached <= (ans_reg != prev_reg);
                        state_reg     <= oas_pkg::ST_DONE;
                    end
                    else
                        state_reg <= oas_pkg::ST_CHECK;
                end
                oas_pkg::ST_DONE:
                begin
                    anomaly_turns <= ans_reg[31:0];
                    done          <= 1'b1;
                    state_reg     <= oas_pkg::ST_IDLE;
                end
                default: state_reg <= oas_pkg::ST_IDLE;
            endcase
        end
    end

    assign busy = (state_reg != oas_pkg::ST_IDLE) || cgo;

endmodule

// ===== hdl/oas_cordic.sv =====
// ----------------------------------------------------------------------------
// oas_cordic: iterative CORDIC sine
// One rotation per cycle on a 32-bit turn angle; result y in Q2.30.
// ----------------------------------------------------------------------------
module oas_cordic
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               go,
    input  logic [31:0]        turn,
    output logic               done,
    output logic signed [33:0] sine
);

    logic signed [33:0] x_reg, y_reg;
    logic signed [33:0] z_reg;
    logic [4:0]         i_reg;
    logic               run_reg;
    logic signed [33:0] z0;
    logic signed [33:0] xs, ys, at;

    // fold the angle into [-1/4, 1/4] turn
    always_comb
    begin
        z0 = {{2{turn[31]}}, turn};
        if (z0 > 34'sh040000000)
            z0 = 34'sh080000000 - z0;
        else if (z0 < -34'sh040000000)
            z0 = -34'sh080000000 - z0;
        xs = x_reg >>> i_reg;
        ys = y_reg >>> i_reg;
        at = {2'b00, oas_pkg::atan_turns(i_reg)};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            done    <= 1'b0;
            i_reg   <= '0;
        end
        else
        begin
            done <= 1'b0;
            if (go)
            begin
                x_reg   <= oas_pkg::CordicGain;
                y_reg   <= '0;
                z_reg   <= z0;
                i_reg   <= '0;
                run_reg <= 1'b1;
            end
            else if (run_reg)
            begin
                if (!z_reg[33])
                begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - at;
                end
                else
                begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + at;
                end
                if (i_reg == 5'(oas_pkg::CordicSteps - 1))
                begin
                    run_reg <= 1'b0;
                    done    <= 1'b1;
                end
                i_reg <= i_reg + 5'd1;
            end
        end
    end

    assign sine = y_reg;

endmodule

// ===== tb/oas_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// oas_checker: anomaly predictor and result scoreboard
// Watches the start and done channels of the solver, computes the expected
// anomaly for every accepted time and compares each done pulse against it.
// ----------------------------------------------------------------------------
module oas_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [47:0] days_since_periapsis,
    input  logic        done,
    input  logic [31:0] anomaly_turns,
    input  logic        limit_reached,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [39:0] cfg_data,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic [31:0] turns;
        logic        limit;
    } anomaly_t;

    localparam logic [31:0] ATAN [oas_pkg::CordicSteps] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001};

    logic [39:0] period_q;
    logic [15:0] ecc_q;
    anomaly_t    anomaly_q[$];

    // sine of a 32-bit turn angle, Q2.30; >>> floors on signed operands
    function automatic longint sine_q30(logic [31:0] turn);
        longint z, x, y, nx;
        z = longint'($signed(turn));
        x = oas_pkg::CordicGain;
        y = 0;
        if (z > 64'sh40000000)
            z = 64'sh80000000 - z;
        else if (z < -64'sh40000000)
            z = -64'sh80000000 - z;
        for (int i = 0; i < oas_pkg::CordicSteps; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - longint'(ATAN[i]);
            end
            else
            begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + longint'(ATAN[i]);
            end
            x = nx;
        end
        return y;
    endfunction

    // e*sin(2pi*a)/(2pi) in turns, rounded half up from Q62
    function automatic longint ecc_turns(longint a);
        longint p;
        p = (longint'(ecc_q) * sine_q30(a[31:0])) >>> 16;
        p = p * longint'(oas_pkg::InvTwoPi);
        return (p + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function automatic anomaly_t solve_anomaly(logic [47:0] t);
        logic [63:0] mag, rem, mean;
        longint      m, ans, prev;
        int          count;
        anomaly_t    r;
        mean = 0;
        prev = 0;
        count = 0;
        r.limit = 1'b0;
        if (period_q != 0)
        begin
            mag = t[47] ? (64'd1 << 48) - t : t;
            rem = mag % period_q;
            if (t[47] && rem != 0)
                rem = period_q - rem;
            for (int i = 0; i < oas_pkg::AngleBits; i++)
            begin
                rem  = rem << 1;
                mean = mean << 1;
                if (rem >= period_q)
                begin
                    rem  = rem - period_q;
                    mean = mean | 1;
                end
            end
        end
        m = longint'(mean);
        ans = m;
        while (ans != prev)
        begin
            prev = ans;
            count++;
            ans = (m - ecc_turns(prev) + prev) >>> 1;
            if (count > oas_pkg::MaxIterations)
            begin
                r.limit = (ans != prev);
                break;
            end
        end
        r.turns = ans[31:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        anomaly_t exp_r;
        if (!rst_n)
        begin
            period_q   <= 40'd23937441;
            ecc_q      <= 16'd1095;
            fail_count <= 0;
            pending    <= 0;
            anomaly_q.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == 1'b0)
                    period_q <= cfg_data;
                else
                    ecc_q <= cfg_data[15:0];
            end
            if (start && !busy)
                anomaly_q.push_back(solve_anomaly(days_since_periapsis));
            if (done)
            begin
                if (anomaly_q.size() == 0)
                begin
                    $error("unexpected result turns=%h limit=%b", anomaly_turns, limit_reached);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_r = anomaly_q.pop_front();
                    if (anomaly_turns !== exp_r.turns)
                    begin
                        $error("anomaly_turns expected %h actual %h", exp_r.turns, anomaly_turns);
                        fail_count <= fail_count + 1;
                    end
                    if (limit_reached !== exp_r.limit)
                    begin
                        $error("limit_reached expected %b actual %b", exp_r.limit, limit_reached);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending <= anomaly_q.size();
        end
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: orbit anomaly solver testbench
// Drives directed and random times through several period and eccentricity
// settings, with random gaps; the checker predicts and scores each result.
// ----------------------------------------------------------------------------
module tb;

    localparam int  RandItems  = 250;
    localparam int  StallLimit = 20000;
    localparam bit  CFG_PERIOD = 1'b0;
    localparam bit  CFG_ECC    = 1'b1;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [47:0] days_since_periapsis;
    logic        done;
    logic [31:0] anomaly_turns;
    logic        limit_reached;
    logic        cfg_we;
    logic        cfg_index;
    logic [39:0] cfg_data;
    int          fail_count;
    int          pending;
    int          quiet_cycles;
    int          sent;

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    orbit_anomaly_solver_core u_dut
    (
        .clk                  (clk),
        .rst_n                (rst_n),
        .start                (start),
        .busy                 (busy),
        .days_since_periapsis (days_since_periapsis),
        .done                 (done),
        .anomaly_turns        (anomaly_turns),
        .limit_reached        (limit_reached),
        .cfg_we               (cfg_we),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data)
    );

    oas_checker u_chk
    (
        .clk                  (clk),
        .rst_n                (rst_n),
        .start                (start),
        .busy                 (busy),
        .days_since_periapsis (days_since_periapsis),
        .done                 (done),
        .anomaly_turns        (anomaly_turns),
        .limit_reached        (limit_reached),
        .cfg_we               (cfg_we),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data),
        .fail_count           (fail_count),
        .pending              (pending)
    );

    // Watchdog: count cycles with no transfer on either channel
    always @(posedge clk)
    begin
        if ((start && !busy) || done || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > StallLimit)
        begin
            $display("orbit_anomaly_solver_core test failed");
            $finish;
        end
    end

    // Idle a random gap: mostly short, now and then long, sometimes none
    task automatic idle_gap();
        int n;
        case ($urandom_range(0, 9))
            0, 1, 2: n = 0;
            9:       n = $urandom_range(50, 300);
            default: n = $urandom_range(1, 8);
        endcase
        repeat (n) @(posedge clk);
    endtask

    // Hold start until the transfer, then drop it for one cycle
    task automatic send_time(logic [47:0] t);
        start <= 1'b1;
        days_since_periapsis <= t;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        start <= 1'b0;
        sent++;
        @(posedge clk);
    endtask

    // Drain every result, then let the solver settle before touching registers
    task automatic drain();
        @(posedge clk);
        while (pending != 0 || busy)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [39:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [47:0] rand_time();
        logic [47:0] t;
        t = 48'({$urandom(), $urandom()});
        case ($urandom_range(0, 3))
            0: t = {{28{t[47]}}, t[19:0]};
            1: t = {{16{t[47]}}, t[31:0]};
            default: ;
        endcase
        return t;
    endfunction

    function automatic logic [39:0] rand_period();
        logic [39:0] p;
        case ($urandom_range(0, 3))
            0: p = 40'($urandom_range(1, 1000));
            1: p = {8'd0, $urandom()};
            2: p = 40'({$urandom(), $urandom()});
            default: p = 40'd23937441;
        endcase
        return p;
    endfunction

    initial
    begin
        logic [47:0] edge_times[];
        rst_n = 1'b0;
        start = 1'b0;
        days_since_periapsis = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_PERIOD;
        cfg_data = '0;
        sent = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset setting: extremes, zero, one period, negatives
        edge_times = '{48'h0, 48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, 48'hFFFF_FFFF_FFFF,
                       48'h1, 48'd23937441, 48'd11968720, -48'sd23937441,
                       48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555};
        foreach (edge_times[i])
            send_time(edge_times[i]);
        drain();

        // Zero period forces a zero mean angle; eccentricity at its maximum
        write_reg(CFG_PERIOD, 40'd0);
        write_reg(CFG_ECC, 40'hFFFF);
        send_time(48'h1234_5678_9ABC);
        send_time(48'h8000_0000_0000);
        drain();

        // Widest period, highest eccentricity; then smallest period, zero eccentricity
        write_reg(CFG_PERIOD, 40'hFF_FFFF_FFFF);
        send_time(48'h7FFF_FFFF_FFFF);
        send_time(48'h8000_0000_0001);
        send_time(48'h3FFF_0000_1234);
        drain();
        write_reg(CFG_PERIOD, 40'd1);
        write_reg(CFG_ECC, 40'd0);
        send_time(48'h0000_0001_8000);
        send_time(48'hFFFF_FFFF_0001);
        drain();
        write_reg(CFG_PERIOD, 40'd3);
        write_reg(CFG_ECC, 40'hF000);
        send_time(48'd1);
        send_time(48'd2);
        send_time(-48'sd1);
        drain();

        // Random phases, each under a fresh setting
        for (int ph = 0; ph < 10; ph++)
        begin
            write_reg(CFG_PERIOD, ph == 0 ? 40'hFF_FFFF_FFFF : rand_period());
            write_reg(CFG_ECC, ph == 1 ? 40'hFFFF : 40'(16'($urandom())));
            for (int k = 0; k < RandItems / 10; k++)
            begin
                idle_gap();
                send_time(rand_time());
                // Hold off until the solver is fully drained, once mid-phase
                if (k == 7)
                    drain();
            end
            drain();
        end

        repeat (50) @(posedge clk);
        $display("Covered %0d times across %0d register settings,", sent, 15);
        $display("including zero and extreme periods and eccentricities.");
        if (fail_count == 0)
            $display("orbit_anomaly_solver_core test passed");
        else
            $display("orbit_anomaly_solver_core test failed");
        $finish;
    end

endmodule
